>>> rtl/core/prff_pkg.sv
`default_nettype none

package prff_pkg;

    localparam int TGT_W  = 17;
    localparam int REG_W  = 16;
    localparam int NN_W   = TGT_W + REG_W;
    localparam int DD_W   = 2 * REG_W;
    localparam int NUM_W  = 32;
    localparam int DEN_W  = 20;
    localparam int APB_W  = 32;
    localparam int ADDR_W = 4;

    // relative tolerance 1/10000, halved because the remainder tracks twice the error
    localparam int TOL_RECIP = 10000;
    localparam int TOL_HALF  = TOL_RECIP / 2;
    localparam int TOL_W     = $clog2(TOL_HALF + 1);

    localparam logic [REG_W-1:0] LEAD_RST   = 16'd2000;
    localparam logic [REG_W-1:0] STEPS_RST  = 16'd200;
    localparam logic [REG_W-1:0] COUNTS_RST = 16'd1024;

    typedef enum logic [1:0] {
        REG_LEAD   = 2'd0,
        REG_STEPS  = 2'd1,
        REG_COUNTS = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_SCALE,
        S_DIV_S,
        S_DIV_Q,
        S_GCD,
        S_DIV_NUM,
        S_DIV_DEN,
        S_STEP,
        S_MULT,
        S_CMP,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/pitch_ratio_fraction_finder.sv
`default_nettype none

// Pitch ratio fraction finder. For each target thread pitch item the block returns one
// reduced gear ratio numerator/denominator (motor steps per encoder count), worked out
// from N = target * motor steps and D = leadscrew pitch * encoder counts with exact
// integer math. The start value floor(N*SCALE/D)/SCALE (clamped to 32 bits, which sets
// the saturated flag) is reduced by its gcd; then denominators 1..MAX_DENOMINATOR are
// tried in order and the first one whose rounded numerator is within 1/10000 relative
// error replaces it when smaller. A zero N gives 0/1; a zero D gives 0xFFFFFFFF/1 with
// saturated set. All division, modulo and gcd work goes through one shared bit-serial
// divider that retires one quotient bit per cycle, working on a dividend of W bits
// with W = 33 + clog2(SCALE+1) (53 at the default scale). The scan stops at the first
// match or before the start denominator, and goes through a step, a tolerance multiply
// and a compare state for each denominator. The block takes one item at a time and is
// ready again once its result sits in the output register.
module pitch_ratio_fraction_finder #(
    parameter int SCALE           = 1000000,
    parameter int MAX_DENOMINATOR = 10000
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // item input
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [prff_pkg::TGT_W-1:0]   i_target_pitch_um,
    // result output
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [prff_pkg::NUM_W-1:0]        o_ratio_numerator,
    output logic [prff_pkg::DEN_W-1:0]        o_ratio_denominator,
    output logic                              o_saturated,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [prff_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [prff_pkg::APB_W-1:0]   pwdata,
    output logic [prff_pkg::APB_W-1:0]        prdata,
    output logic                              pready
);

    import prff_pkg::*;

    localparam int DW    = $clog2(MAX_DENOMINATOR + 1);
    localparam int SW    = $clog2(SCALE + 1);
    localparam int DIVW  = NN_W + SW;
    localparam int ND_W  = NN_W + DW;
    localparam int TP_W  = DD_W + TOL_W;
    localparam int CMP_W = (ND_W > TP_W) ? ND_W : TP_W;

    // configuration registers
    logic [REG_W-1:0] r_lead;
    logic [REG_W-1:0] r_steps;
    logic [REG_W-1:0] r_counts;
    t_reg_idx         w_idx;

    // sequencer
    t_state r_state;
    t_state n_state;
    logic   r_issued;

    // operands and intermediate values
    logic [TGT_W-1:0] r_tgt;
    logic [NN_W-1:0]  r_nn;
    logic [DD_W-1:0]  r_dd;
    logic [DIVW-1:0]  r_prod;
    logic [NUM_W-1:0] r_s;
    logic [DD_W-1:0]  r_ga;
    logic [DD_W-1:0]  r_gb;
    logic [NUM_W-1:0] r_num;
    logic [SW-1:0]    r_den;
    logic [NN_W-1:0]  r_qi;
    logic [DD_W-1:0]  r_ri;

    // denominator scan
    logic [DW-1:0]   r_d;
    logic [ND_W-1:0] r_nd;
    logic [ND_W-1:0] r_n;
    logic [DD_W:0]   r_rem;
    logic [TP_W-1:0] r_tolp;

    // result being built and output register
    logic [NUM_W-1:0] r_res_num;
    logic [DEN_W-1:0] r_res_den;
    logic             r_res_sat;
    logic             r_out_valid;
    logic [NUM_W-1:0] r_out_num;
    logic [DEN_W-1:0] r_out_den;
    logic             r_out_sat;

    // shared divider
    logic             w_div_start;
    logic [DIVW-1:0]  w_div_dividend;
    logic [DD_W-1:0]  w_div_divisor;
    logic             w_div_done;
    logic [DIVW-1:0]  w_quot;
    logic [DD_W-1:0]  w_drem;

    // scan helpers
    logic [DD_W+1:0]  w_sum;
    logic             w_carry;
    logic [DD_W-1:0]  w_abs;
    logic             w_ok;
    logic             w_more;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_load;
    logic             w_cfg_wr;
    logic [DIVW-1:0]  w_s_clamped;
    logic             w_s_sat;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = r_out_valid && i_out_ready;
    assign w_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_idx     = t_reg_idx'(paddr[3:2]);

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= LEAD_RST;
            r_steps  <= STEPS_RST;
            r_counts <= COUNTS_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_LEAD:   r_lead   <= pwdata[REG_W-1:0];
                REG_STEPS:  r_steps  <= pwdata[REG_W-1:0];
                REG_COUNTS: r_counts <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LEAD:   prdata = APB_W'(r_lead);
            REG_STEPS:  prdata = APB_W'(r_steps);
            REG_COUNTS: prdata = APB_W'(r_counts);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- shared divider ----------------
    prff_div #(
        .DIVIDEND_W (DIVW),
        .DIVISOR_W  (DD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_drem)
    );

    // clamp of the scaled start numerator to 32 bits
    assign w_s_sat     = (w_quot[DIVW-1:NUM_W] != '0);
    assign w_s_clamped = w_s_sat ? DIVW'({NUM_W{1'b1}}) : w_quot;

    // ---------------- scan arithmetic ----------------
    // remainder of (2*N*d + D) / (2*D) advances by 2*(N mod D) per denominator
    always_comb begin
        w_sum   = (DD_W+2)'(r_rem) + (DD_W+2)'({r_ri, 1'b0});
        w_carry = (w_sum >= (DD_W+2)'({r_dd, 1'b0}));
        // |rem - D| is twice the error |n*D - N*d|
        if (r_rem >= (DD_W+1)'(r_dd)) begin
            w_abs = DD_W'(r_rem - (DD_W+1)'(r_dd));
        end else begin
            w_abs = DD_W'((DD_W+1)'(r_dd) - r_rem);
        end
        w_ok   = (CMP_W'(r_tolp) < CMP_W'(r_nd)) && (r_n[ND_W-1:NUM_W] == '0);
        w_more = (32'(r_d) < 32'(MAX_DENOMINATOR)) && ((32'(r_d) + 32'd1) < 32'(r_den));
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_in_acc) n_state = S_PROD;
            S_PROD:    n_state = S_SCALE;
            S_SCALE: begin
                if (r_nn == '0 || r_dd == '0) n_state = S_OUT;
                else n_state = S_DIV_S;
            end
            S_DIV_S:   if (w_div_done) n_state = S_DIV_Q;
            S_DIV_Q:   if (w_div_done) n_state = S_GCD;
            S_GCD:     if (r_gb == '0) n_state = S_DIV_NUM;
            S_DIV_NUM: if (w_div_done) n_state = S_DIV_DEN;
            S_DIV_DEN: begin
                if (w_div_done) begin
                    n_state = (w_quot > DIVW'(1)) ? S_STEP : S_OUT;
                end
            end
            S_STEP:    n_state = S_MULT;
            S_MULT:    n_state = S_CMP;
            S_CMP:     n_state = (w_ok || !w_more) ? S_OUT : S_STEP;
            S_OUT:     if (w_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer: divider control ----------------
    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = r_prod;
        w_div_divisor  = r_dd;
        unique case (r_state)
            S_DIV_S: begin
                w_div_start    = !r_issued;
                w_div_dividend = r_prod;
                w_div_divisor  = r_dd;
            end
            S_DIV_Q: begin
                w_div_start    = !r_issued;
                w_div_dividend = DIVW'(r_nn);
                w_div_divisor  = r_dd;
            end
            S_GCD: begin
                w_div_start    = !r_issued && (r_gb != '0);
                w_div_dividend = DIVW'(r_ga);
                w_div_divisor  = r_gb;
            end
            S_DIV_NUM: begin
                w_div_start    = !r_issued;
                w_div_dividend = DIVW'(r_s);
                w_div_divisor  = r_ga;
            end
            S_DIV_DEN: begin
                w_div_start    = !r_issued;
                w_div_dividend = DIVW'(SCALE);
                w_div_divisor  = r_ga;
            end
            default: ;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_div_start) r_issued <= 1'b1;
            else if (w_div_done) r_issued <= 1'b0;
            if (w_load) r_out_valid <= 1'b1;
            else if (w_out_acc) r_out_valid <= 1'b0;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) r_tgt <= i_target_pitch_um;
            end
            S_PROD: begin
                r_nn <= NN_W'(r_tgt) * NN_W'(r_steps);
                r_dd <= DD_W'(r_lead) * DD_W'(r_counts);
            end
            S_SCALE: begin
                r_prod <= DIVW'(r_nn) * DIVW'(SCALE);
                // zero steps or target: ratio zero
                if (r_nn == '0) begin
                    r_res_num <= '0;
                    r_res_den <= DEN_W'(1);
                    r_res_sat <= 1'b0;
                end else begin
                    // zero pitch or count: infinite ratio, shown as the largest value
                    r_res_num <= '1;
                    r_res_den <= DEN_W'(1);
                    r_res_sat <= 1'b1;
                end
            end
            S_DIV_S: begin
                if (w_div_done) begin
                    r_s       <= NUM_W'(w_s_clamped);
                    r_res_sat <= w_s_sat;
                    r_ga      <= DD_W'(w_s_clamped);
                    r_gb      <= DD_W'(SCALE);
                end
            end
            S_DIV_Q: begin
                if (w_div_done) begin
                    r_qi <= NN_W'(w_quot);
                    r_ri <= w_drem;
                end
            end
            S_GCD: begin
                // one Euclid step per divide
                if (w_div_done) begin
                    r_ga <= r_gb;
                    r_gb <= w_drem;
                end
            end
            S_DIV_NUM: begin
                if (w_div_done) r_num <= NUM_W'(w_quot);
            end
            S_DIV_DEN: begin
                if (w_div_done) begin
                    r_den     <= SW'(w_quot);
                    r_res_num <= r_num;
                    r_res_den <= DEN_W'(w_quot);
                    r_d       <= '0;
                    r_nd      <= '0;
                    r_n       <= '0;
                    r_rem     <= (DD_W+1)'(r_dd);
                end
            end
            S_STEP: begin
                r_d   <= r_d + DW'(1);
                r_nd  <= r_nd + ND_W'(r_nn);
                r_n   <= r_n + ND_W'(r_qi) + ND_W'(w_carry);
                r_rem <= w_carry ? (DD_W+1)'(w_sum - (DD_W+2)'({r_dd, 1'b0}))
                                 : (DD_W+1)'(w_sum);
            end
            S_MULT: begin
                r_tolp <= TP_W'(w_abs) * TP_W'(TOL_HALF);
            end
            S_CMP: begin
                // first match is already in lowest terms and below the start denominator
                if (w_ok) begin
                    r_res_num <= NUM_W'(r_n);
                    r_res_den <= DEN_W'(r_d);
                end
            end
            S_OUT: begin
                if (w_load) begin
                    r_out_num <= r_res_num;
                    r_out_den <= r_res_den;
                    r_out_sat <= r_res_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_ratio_numerator   = r_out_num;
    assign o_ratio_denominator = r_out_den;
    assign o_saturated         = r_out_sat;

    // ---------------- checks ----------------
    // the divider only finishes while the sequencer waits on it
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV_S || r_state == S_DIV_Q || r_state == S_GCD ||
                        r_state == S_DIV_NUM || r_state == S_DIV_DEN))
        else $error("divider finished outside a divide state");

    // an accepted item starts the product stage
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_PROD))
        else $error("accepted item did not start the sequence");

    // the scan never compares a denominator outside 1..MAX_DENOMINATOR
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_d != '0 && 32'(r_d) <= 32'(MAX_DENOMINATOR)))
        else $error("scan denominator out of range");

endmodule

`default_nettype wire

>>> rtl/core/prff_div.sv
`default_nettype none

module prff_div #(
    parameter int DIVIDEND_W = 64,
    parameter int DIVISOR_W  = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quot,
    output logic [DIVISOR_W-1:0]       o_rem
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0] w_sh;
    logic [DIVISOR_W:0] w_diff;
    logic               w_ge;

    // one restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_sh   = {r_rem, r_quot[DIVIDEND_W-1]};
        w_ge   = (w_sh >= {1'b0, r_div});
        w_diff = w_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIVIDEND_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[DIVISOR_W-1:0] : w_sh[DIVISOR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire
